// ===== hw/rtl/pcv_pkg.sv =====
`default_nettype none

package pcv_pkg;

  localparam int DEPTH  = 8;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CODE_W = 16;
  localparam int GRADE_W = 3;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef logic [GRADE_W-1:0] grade_t;

  localparam grade_t GRADE_INVALID     = 3'd0;
  localparam grade_t GRADE_UNLIKELY    = 3'd1;
  localparam grade_t GRADE_LIKELY      = 3'd2;
  localparam grade_t GRADE_VERY_LIKELY = 3'd3;
  localparam grade_t GRADE_CORRECT     = 3'd4;

  typedef struct packed {
    logic              err;
    logic [CODE_W-1:0] code;
  } hist_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    hist_entry_t       wdata;
    logic [SLOT_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } scan_state_t;

  // Both counts saturate at three, which is all the grading needs.
  function automatic grade_t grade_of(input logic [1:0] n_match, input logic [1:0] clean);
    grade_t g;
    if (clean >= 2'd2) begin
      g = GRADE_CORRECT;
    end else if (n_match >= 2'd2 && clean >= 2'd1) begin
      g = GRADE_VERY_LIKELY;
    end else if (n_match == 2'd3) begin
      g = GRADE_LIKELY;
    end else if (n_match == 2'd2 || clean >= 2'd1) begin
      g = GRADE_UNLIKELY;
    end else begin
      g = GRADE_INVALID;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pcv_hist_mem.sv =====
`default_nettype none

module pcv_hist_mem (
  input  wire logic              clk,
  input  wire pcv_pkg::mem_req_t req,
  output pcv_pkg::hist_entry_t   rd_data
);
  import pcv_pkg::*;

  hist_entry_t mem [DEPTH];
  hist_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pcv_scan.sv =====
`default_nettype none

module pcv_scan (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       in_cmd,
  input  wire logic [pcv_pkg::CODE_W-1:0] in_code,
  input  wire logic                       in_err,
  output pcv_pkg::mem_req_t               mem_req,
  input  wire pcv_pkg::hist_entry_t       mem_rdata,
  output logic                            res_valid,
  input  wire logic                       res_ready,
  output pcv_pkg::grade_t                 res_grade,
  output logic [pcv_pkg::CODE_W-1:0]      res_value
);
  import pcv_pkg::*;

  scan_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt;
  logic [CNT_W-1:0]  filled_r, filled_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic [1:0]        match_r, match_nxt;
  logic [1:0]        clean_r, clean_nxt;
  logic              accept;
  logic              last_idx;
  logic [SLOT_W-1:0] slot_inc;
  logic              hit;

  assign accept   = in_valid && in_ready;
  assign last_idx = (idx_r == SLOT_W'(filled_r - 1'b1));
  assign slot_inc = (wslot_r == SLOT_W'(DEPTH - 1)) ? '0 : wslot_r + 1'b1;
  assign hit      = pend_r && (mem_rdata.code == code_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_cmd == CMD_CLEAR) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = slot_inc;
    mem_req.wdata = '{err: in_err, code: in_code};
    mem_req.raddr = idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        mem_req.we = in_valid && (in_cmd == CMD_ADD);
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    wslot_nxt  = wslot_r;
    filled_nxt = filled_r;
    idx_nxt    = idx_r;
    pend_nxt   = 1'b0;
    code_nxt   = code_r;
    match_nxt  = match_r;
    clean_nxt  = clean_r;
    if (hit) begin
      if (match_r != 2'd3) begin
        match_nxt = match_r + 1'b1;
      end
      if (!mem_rdata.err && clean_r != 2'd3) begin
        clean_nxt = clean_r + 1'b1;
      end
    end
    if (state_r == ST_IDLE && accept) begin
      idx_nxt = '0;
      if (in_cmd == CMD_CLEAR) begin
        wslot_nxt  = SLOT_W'(DEPTH - 1);
        filled_nxt = '0;
        code_nxt   = '0;
        match_nxt  = 2'd0;
        clean_nxt  = 2'd0;
      end else begin
        wslot_nxt  = slot_inc;
        filled_nxt = (filled_r == CNT_W'(DEPTH)) ? filled_r : filled_r + 1'b1;
        code_nxt   = in_code;
        match_nxt  = 2'd1;
        clean_nxt  = {1'b0, !in_err};
      end
    end else if (state_r == ST_SCAN) begin
      pend_nxt = (idx_r != wslot_r);
      idx_nxt  = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wslot_r  <= SLOT_W'(DEPTH - 1);
      filled_r <= '0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wslot_r  <= wslot_nxt;
      filled_r <= filled_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    code_r  <= code_nxt;
    match_r <= match_nxt;
    clean_r <= clean_nxt;
  end

  assign res_grade = grade_of(match_r, clean_r);
  assign res_value = code_r;

`ifndef SYNTHESIS
  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= CNT_W'(DEPTH))
    else $error("history fill count exceeds the ring depth");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_CLEAR) |=>
      (filled_r == '0 && wslot_r == SLOT_W'(DEPTH - 1) && state_r == ST_DONE))
    else $error("clear request did not empty the history");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SCAN || state_r == ST_FLUSH))
    else $error("read data counted outside the scan");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == ST_IDLE && in_valid))
    else $error("history written outside an accepted add request");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pi_code_confidence_voter.sv =====
`default_nettype none

// Channel  Direction  tdata              tuser
// in_      slave      code_value[15:0]   {had_error, command}
// out_     master     graded_value[15:0] grade[2:0]
//
// An add request walks the filled history, one entry read per cycle
// through the single read port of the history memory.
// A clear request skips the walk and goes straight to its result.
// Reset is synchronous and active low; it empties the history without touching memory.
// One request is in work at a time; the output register lets a new request be taken
// while the previous result waits, and a finished result waits when out_tready is low.

module pi_code_confidence_voter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [15:0] code_value
  input  wire logic [1:0]  in_tuser,  // [0] command, [1] had_error
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata, // [15:0] graded_value
  output logic [2:0]       out_tuser  // [2:0] grade
);
  import pcv_pkg::*;

  mem_req_t          mem_req;
  hist_entry_t       mem_rdata;
  logic              res_valid;
  logic              res_ready;
  grade_t            res_grade;
  logic [CODE_W-1:0] res_value;
  logic              out_valid_r;
  grade_t            out_grade_r;
  logic [CODE_W-1:0] out_value_r;

  pcv_hist_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rdata)
  );

  pcv_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser[0]),
    .in_code   (in_tdata),
    .in_err    (in_tuser[1]),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_grade (res_grade),
    .res_value (res_value)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_grade_r <= res_grade;
      out_value_r <= res_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_grade_r;

endmodule

`default_nettype wire

// ===== sim/pi_code_confidence_voter_tb.sv =====
`timescale 1ns / 100ps

module pi_code_confidence_voter_tb;
  import pcv_pkg::*;

  typedef struct packed {
    grade_t      grade;
    logic [15:0] value;
  } verdict_t;

  typedef struct packed {
    logic        cmd;
    logic [15:0] code;
    logic        err;
    logic        known;
    grade_t      grade;
    logic [15:0] value;
  } directed_row_t;

  localparam int N_DIRECTED  = 22;
  localparam int N_RANDOM    = 1700;
  localparam int POOL_SIZE   = 4;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  logic [15:0] seen_code [DEPTH];
  logic        seen_err  [DEPTH];
  int          last_slot;
  int          fill_level;
  verdict_t    pending_verdicts [$];
  int          mismatch_count;
  bit          no_idle;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_ADD,   16'h0000, 1'b0, 1'b1, GRADE_UNLIKELY, 16'h0000},
    '{CMD_ADD,   16'h0000, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'hFFFF, 1'b1, 1'b1, GRADE_INVALID,  16'hFFFF},
    '{CMD_ADD,   16'hFFFF, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'hFFFF, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h0000, 1'b0, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_CLEAR, 16'hFFFF, 1'b1, 1'b1, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'hFFFF, 1'b0, 1'b1, GRADE_UNLIKELY, 16'hFFFF},
    '{CMD_CLEAR, 16'h0000, 1'b0, 1'b1, GRADE_INVALID,  16'h0000},
    '{CMD_CLEAR, 16'hFFFF, 1'b1, 1'b1, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b0, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b0, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b1, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h7FFE, 1'b0, 1'b0, GRADE_INVALID,  16'h0000},
    '{CMD_ADD,   16'h8001, 1'b0, 1'b0, GRADE_INVALID,  16'h0000}
  };

  pi_code_confidence_voter u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  function automatic verdict_t vote_on(input logic cmd, input logic [15:0] code,
                                       input logic err);
    verdict_t v;
    int       n_match;
    int       clean;
    n_match = 0;
    clean   = 0;
    if (cmd == CMD_CLEAR) begin
      fill_level = 0;
      last_slot  = DEPTH - 1;
      v.grade    = GRADE_INVALID;
      v.value    = 16'h0000;
      return v;
    end
    last_slot = (last_slot + 1) % DEPTH;
    seen_code[last_slot] = code;
    seen_err[last_slot]  = err;
    if (fill_level < DEPTH) begin
      fill_level++;
    end
    for (int i = 0; i < fill_level; i++) begin
      if (seen_code[i] == code) begin
        n_match++;
        if (!seen_err[i]) begin
          clean++;
        end
      end
    end
    if (clean >= 2) begin
      v.grade = GRADE_CORRECT;
    end else if (n_match >= 2 && clean >= 1) begin
      v.grade = GRADE_VERY_LIKELY;
    end else if (n_match >= 3) begin
      v.grade = GRADE_LIKELY;
    end else if (n_match == 2 || clean >= 1) begin
      v.grade = GRADE_UNLIKELY;
    end else begin
      v.grade = GRADE_INVALID;
    end
    v.value = code;
    return v;
  endfunction

  task automatic send_request(input logic cmd, input logic [15:0] code, input logic err,
                              input logic known, input verdict_t typed);
    int       gap;
    verdict_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tuser  <= {err, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = vote_on(cmd, code, err);
    pending_verdicts.push_back(known ? typed : predicted);
  endtask

  initial begin : result_sink
    int       stall;
    verdict_t want;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, grade %0d value %h", $time, out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_tuser !== want.grade) begin
          $display("%0t: grade expected %0d actual %0d", $time, want.grade, out_tuser);
          mismatch_count++;
        end
        if (out_tdata !== want.value) begin
          $display("%0t: graded_value expected %h actual %h", $time, want.value, out_tdata);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [15:0] pool [POOL_SIZE];
    logic        cmd;
    logic [15:0] code;
    logic        err;
    verdict_t    typed;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = 16'h0000;
    in_tuser       = 2'b00;
    no_idle        = 1'b0;
    mismatch_count = 0;
    fill_level     = 0;
    last_slot      = DEPTH - 1;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      typed.grade = directed_rows[i].grade;
      typed.value = directed_rows[i].value;
      send_request(directed_rows[i].cmd, directed_rows[i].code, directed_rows[i].err,
                   directed_rows[i].known, typed);
    end

    typed = '0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 64 == 0) begin
        foreach (pool[k]) pool[k] = 16'($urandom);
      end
      if (n % 100 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (n == N_RANDOM / 2) begin
        // Hold back further requests until the block has drained.
        @(negedge clk) in_tvalid <= 1'b0;
        wait (pending_verdicts.size() == 0);
      end
      cmd  = ($urandom_range(0, 39) == 0) ? CMD_CLEAR : CMD_ADD;
      code = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                         : 16'($urandom);
      err  = ($urandom_range(0, 2) == 0);
      send_request(cmd, code, err, 1'b0, typed);
    end

    @(negedge clk) in_tvalid <= 1'b0;
    wait (pending_verdicts.size() == 0);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pi_code_confidence_voter verification clean");
    end else begin
      $display("pi_code_confidence_voter verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("pi_code_confidence_voter verification failed");
    $finish;
  end

endmodule
